// File: rtl/hsvled_pkg.sv
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared widths, sector codes and types for the HSV to RGB LED duty pipeline.
// ----------------------------------------------------------------------------
package hsvled_pkg;

    // Input fields are 24-bit two's complement, duty outputs are 8 bits.
    localparam int IN_W  = 24;
    localparam int OUT_W = 8;
    // Magnitude arithmetic needs one more bit to hold 2**IN_W, used to negate a field.
    localparam int MAG_W = IN_W + 1;

    typedef logic [2:0] sector_t;

    localparam sector_t SEC_R_Y  = 3'd0;   // red to yellow
    localparam sector_t SEC_Y_G  = 3'd1;   // yellow to green
    localparam sector_t SEC_G_C  = 3'd2;   // green to cyan
    localparam sector_t SEC_C_B  = 3'd3;   // cyan to blue
    localparam sector_t SEC_B_M  = 3'd4;   // blue to magenta
    localparam sector_t SEC_M_R  = 3'd5;   // magenta to red
    localparam sector_t SEC_WRAP = 3'd6;   // hue of exactly one turn

endpackage

// File: rtl/hsvled_if.sv
// ----------------------------------------------------------------------------
// hsvled_in_if / hsvled_out_if
// Valid/ready channels for HSV requests and RGB duty results.
// ----------------------------------------------------------------------------
interface hsvled_in_if;
    import hsvled_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] hue_in;
    logic signed [IN_W-1:0] sat_in;
    logic signed [IN_W-1:0] val_in;

    modport source (output valid, output hue_in, output sat_in, output val_in,
                    input ready);
    modport sink   (input valid, input hue_in, input sat_in, input val_in,
                    output ready);
endinterface

interface hsvled_out_if;
    import hsvled_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] red_duty;
    logic [OUT_W-1:0] green_duty;
    logic [OUT_W-1:0] blue_duty;

    modport source (output valid, output red_duty, output green_duty,
                    output blue_duty, input ready);
    modport sink   (input valid, input red_duty, input green_duty,
                    input blue_duty, output ready);
endinterface

// File: rtl/hsv_to_rgb_led_drive_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_drive_unit
// Five-stage pipeline turning HSV fixed-point requests into RGB duty values.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  hsv_chan   in   valid/ready    hue_in, sat_in, val_in (24b signed)
//  rgb_chan   out  valid/ready    red_duty, green_duty, blue_duty (8b)
//  cfg        in   cfg_we         cfg_wdata -> common_anode
//
//  One request per cycle while the output is not stalled; one register stage
//  each for fold, sector split, f*s and p, q and t, and duty scale.
//  Reset clears valid bits and common_anode; data registers are not reset.
//  Each stage holds while the one after it is full and stalled; empty stages
//  keep filling, so a request is taken while a result waits at the output.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_drive_unit #(
    parameter int FRAC_BITS = 16,
    parameter int OUT_MAX   = 255
) (
    input  logic          clk,
    input  logic          rst_n,
    hsvled_in_if.sink     hsv_chan,
    hsvled_out_if.source  rgb_chan,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);
    import hsvled_pkg::*;

    logic                 common_anode_reg;
    logic                 front_vld, front_rdy;
    logic                 mix_vld, mix_rdy;
    sector_t              sec_a, sec_b;
    logic [FRAC_BITS-1:0] frac_a;
    logic [FRAC_BITS:0]   sat_a, val_a, oms_a;
    logic [FRAC_BITS:0]   val_b, p_b, q_b, t_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            common_anode_reg <= 1'b0;
        else if (cfg_we)
            common_anode_reg <= cfg_wdata;
    end

    hsvled_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (hsv_chan.valid),
        .in_rdy        (hsv_chan.ready),
        .hue_raw       (hsv_chan.hue_in),
        .sat_raw       (hsv_chan.sat_in),
        .val_raw       (hsv_chan.val_in),
        .out_vld       (front_vld),
        .out_rdy       (front_rdy),
        .sector        (sec_a),
        .frac          (frac_a),
        .sat           (sat_a),
        .val           (val_a),
        .one_minus_sat (oms_a)
    );

    hsvled_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (front_vld),
        .in_rdy        (front_rdy),
        .sector_in     (sec_a),
        .frac          (frac_a),
        .sat           (sat_a),
        .val_in        (val_a),
        .one_minus_sat (oms_a),
        .out_vld       (mix_vld),
        .out_rdy       (mix_rdy),
        .sector_out    (sec_b),
        .val_out       (val_b),
        .p_out         (p_b),
        .q_out         (q_b),
        .t_out         (t_b)
    );

    hsvled_duty #(.FRAC_BITS(FRAC_BITS), .OUT_MAX(OUT_MAX)) u_duty (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (mix_vld),
        .in_rdy       (mix_rdy),
        .sector       (sec_b),
        .val          (val_b),
        .p            (p_b),
        .q            (q_b),
        .t            (t_b),
        .common_anode (common_anode_reg),
        .out_vld      (rgb_chan.valid),
        .out_rdy      (rgb_chan.ready),
        .red_duty     (rgb_chan.red_duty),
        .green_duty   (rgb_chan.green_duty),
        .blue_duty    (rgb_chan.blue_duty)
    );

endmodule

// File: rtl/hsvled_fold.sv
// ----------------------------------------------------------------------------
// hsvled_fold
// Absolute value of a 24-bit field, folded into 0..1.0 (fraction kept above).
// ----------------------------------------------------------------------------
module hsvled_fold #(
    parameter int FRAC_BITS = 16
) (
    input  logic [hsvled_pkg::IN_W-1:0] raw,
    output logic [FRAC_BITS:0]          unit
);
    import hsvled_pkg::*;

    localparam logic [MAG_W-1:0] ONE_M  = MAG_W'(1) << FRAC_BITS;
    localparam logic [MAG_W-1:0] WRAP_M = MAG_W'(1) << IN_W;

    logic [MAG_W-1:0] mag;

    assign mag  = raw[IN_W-1] ? (WRAP_M - {1'b0, raw}) : {1'b0, raw};
    // exactly 1.0 stays 1.0; anything above keeps its fraction only
    assign unit = (mag > ONE_M) ? {1'b0, mag[FRAC_BITS-1:0]} : mag[FRAC_BITS:0];

endmodule

// File: rtl/hsvled_front.sv
// ----------------------------------------------------------------------------
// hsvled_front
// Stage 1 folds h, s, v; stage 2 splits hue*6 into sector and fraction.
// ----------------------------------------------------------------------------
module hsvled_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    output logic                            in_rdy,
    input  logic [hsvled_pkg::IN_W-1:0]     hue_raw,
    input  logic [hsvled_pkg::IN_W-1:0]     sat_raw,
    input  logic [hsvled_pkg::IN_W-1:0]     val_raw,
    output logic                            out_vld,
    input  logic                            out_rdy,
    output hsvled_pkg::sector_t             sector,
    output logic [FRAC_BITS-1:0]            frac,
    output logic [FRAC_BITS:0]              sat,
    output logic [FRAC_BITS:0]              val,
    output logic [FRAC_BITS:0]              one_minus_sat
);
    import hsvled_pkg::*;

    localparam int UW   = FRAC_BITS + 1;
    localparam int H6_W = FRAC_BITS + 3;
    localparam logic [UW-1:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

    logic [UW-1:0]        h_fold, s_fold, v_fold;
    logic                 vld1_reg, vld2_reg;
    logic                 en1, en2;
    logic [UW-1:0]        h1_reg, s1_reg, v1_reg;
    logic [H6_W-1:0]      h6;
    sector_t              sec_raw, sec_next;
    sector_t              sec2_reg;
    logic [FRAC_BITS-1:0] f2_reg;
    logic [UW-1:0]        s2_reg, v2_reg, oms2_reg;

    hsvled_fold #(.FRAC_BITS(FRAC_BITS)) u_fold_h (.raw(hue_raw), .unit(h_fold));
    hsvled_fold #(.FRAC_BITS(FRAC_BITS)) u_fold_s (.raw(sat_raw), .unit(s_fold));
    hsvled_fold #(.FRAC_BITS(FRAC_BITS)) u_fold_v (.raw(val_raw), .unit(v_fold));

    assign en2    = !vld2_reg || out_rdy;
    assign en1    = !vld1_reg || en2;
    assign in_rdy = en1;

    // hue*6 as 4h + 2h
    assign h6       = (H6_W'(h1_reg) << 2) + (H6_W'(h1_reg) << 1);
    assign sec_raw  = h6[FRAC_BITS+2:FRAC_BITS];
    assign sec_next = (sec_raw == SEC_WRAP) ? SEC_R_Y : sec_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                vld1_reg <= in_vld;
            if (en2)
                vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            h1_reg <= h_fold;
            s1_reg <= s_fold;
            v1_reg <= v_fold;
        end
        if (en2)
        begin
            sec2_reg <= sec_next;
            f2_reg   <= h6[FRAC_BITS-1:0];
            s2_reg   <= s1_reg;
            v2_reg   <= v1_reg;
            oms2_reg <= ONE_U - s1_reg;
        end
    end

    assign out_vld       = vld2_reg;
    assign sector        = sec2_reg;
    assign frac          = f2_reg;
    assign sat           = s2_reg;
    assign val           = v2_reg;
    assign one_minus_sat = oms2_reg;

endmodule

// File: rtl/hsvled_mix.sv
// ----------------------------------------------------------------------------
// hsvled_mix
// Stage 3 forms f*s and p; stage 4 forms q and t.
// ----------------------------------------------------------------------------
module hsvled_mix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    output logic                 in_rdy,
    input  hsvled_pkg::sector_t  sector_in,
    input  logic [FRAC_BITS-1:0] frac,
    input  logic [FRAC_BITS:0]   sat,
    input  logic [FRAC_BITS:0]   val_in,
    input  logic [FRAC_BITS:0]   one_minus_sat,
    output logic                 out_vld,
    input  logic                 out_rdy,
    output hsvled_pkg::sector_t  sector_out,
    output logic [FRAC_BITS:0]   val_out,
    output logic [FRAC_BITS:0]   p_out,
    output logic [FRAC_BITS:0]   q_out,
    output logic [FRAC_BITS:0]   t_out
);
    import hsvled_pkg::*;

    localparam int UW  = FRAC_BITS + 1;
    localparam int FSW = 2 * FRAC_BITS + 1;
    localparam int PW  = 2 * FRAC_BITS + 2;
    localparam logic [UW-1:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

    logic          vld3_reg, vld4_reg;
    logic          en3, en4;
    logic [FSW-1:0] fs_prod;
    logic [PW-1:0]  p_prod, q_prod, t_prod;
    sector_t        sec3_reg, sec4_reg;
    logic [UW-1:0]  v3_reg, oms3_reg, fs3_reg, p3_reg;
    logic [UW-1:0]  v4_reg, p4_reg, q4_reg, t4_reg;
    logic [UW-1:0]  one_minus_fs, oms_plus_fs;

    assign en4    = !vld4_reg || out_rdy;
    assign en3    = !vld3_reg || en4;
    assign in_rdy = en3;

    assign fs_prod = FSW'(frac) * FSW'(sat);
    assign p_prod  = PW'(val_in) * PW'(one_minus_sat);

    // s >= f*s since f < 1, so 1 - s + fs stays within 0..1.0
    assign one_minus_fs = ONE_U - fs3_reg;
    assign oms_plus_fs  = oms3_reg + fs3_reg;
    assign q_prod       = PW'(v3_reg) * PW'(one_minus_fs);
    assign t_prod       = PW'(v3_reg) * PW'(oms_plus_fs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                vld3_reg <= in_vld;
            if (en4)
                vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sec3_reg <= sector_in;
            v3_reg   <= val_in;
            oms3_reg <= one_minus_sat;
            fs3_reg  <= fs_prod[2*FRAC_BITS:FRAC_BITS];
            p3_reg   <= p_prod[2*FRAC_BITS:FRAC_BITS];
        end
        if (en4)
        begin
            sec4_reg <= sec3_reg;
            v4_reg   <= v3_reg;
            p4_reg   <= p3_reg;
            q4_reg   <= q_prod[2*FRAC_BITS:FRAC_BITS];
            t4_reg   <= t_prod[2*FRAC_BITS:FRAC_BITS];
        end
    end

    assign out_vld    = vld4_reg;
    assign sector_out = sec4_reg;
    assign val_out    = v4_reg;
    assign p_out      = p4_reg;
    assign q_out      = q4_reg;
    assign t_out      = t4_reg;

endmodule

// File: rtl/hsvled_duty.sv
// ----------------------------------------------------------------------------
// hsvled_duty
// Stage 5: channel pick by sector, scale to duty with rounding, anode invert.
// ----------------------------------------------------------------------------
module hsvled_duty #(
    parameter int FRAC_BITS = 16,
    parameter int OUT_MAX   = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_vld,
    output logic                         in_rdy,
    input  hsvled_pkg::sector_t          sector,
    input  logic [FRAC_BITS:0]           val,
    input  logic [FRAC_BITS:0]           p,
    input  logic [FRAC_BITS:0]           q,
    input  logic [FRAC_BITS:0]           t,
    input  logic                         common_anode,
    output logic                         out_vld,
    input  logic                         out_rdy,
    output logic [hsvled_pkg::OUT_W-1:0] red_duty,
    output logic [hsvled_pkg::OUT_W-1:0] green_duty,
    output logic [hsvled_pkg::OUT_W-1:0] blue_duty
);
    import hsvled_pkg::*;

    localparam int UW   = FRAC_BITS + 1;
    localparam int OM_W = $clog2(OUT_MAX + 1);
    localparam int SW   = UW + OM_W;
    localparam int XW   = (OM_W > OUT_W) ? OM_W : OUT_W;
    localparam logic [SW-1:0]   HALF   = SW'(1) << (FRAC_BITS - 1);
    localparam logic [SW-1:0]   SCALE  = SW'(OUT_MAX);
    localparam logic [OM_W-1:0] OM_MAX = OM_W'(OUT_MAX);

    logic          vld5_reg;
    logic          en5;
    logic [UW-1:0] r_sel, g_sel, b_sel;
    logic [OUT_W-1:0] red_reg, green_reg, blue_reg;

    // c <= 1.0, so the rounded duty never passes OUT_MAX
    function automatic logic [OUT_W-1:0] scale(input logic [UW-1:0] c, input logic inv);
        logic [SW-1:0]   prod;
        logic [OM_W-1:0] d;
        logic [XW-1:0]   dx;
        prod = SW'(c) * SCALE + HALF;
        d    = prod[FRAC_BITS+OM_W-1:FRAC_BITS];
        if (inv)
            d = OM_MAX - d;
        dx = XW'(d);
        return dx[OUT_W-1:0];
    endfunction

    always_comb
    begin
        unique case (sector)
            SEC_R_Y:
            begin
                r_sel = val; g_sel = t;   b_sel = p;
            end
            SEC_Y_G:
            begin
                r_sel = q;   g_sel = val; b_sel = p;
            end
            SEC_G_C:
            begin
                r_sel = p;   g_sel = val; b_sel = t;
            end
            SEC_C_B:
            begin
                r_sel = p;   g_sel = q;   b_sel = val;
            end
            SEC_B_M:
            begin
                r_sel = t;   g_sel = p;   b_sel = val;
            end
            default:
            begin
                r_sel = val; g_sel = p;   b_sel = q;
            end
        endcase
    end

    assign en5    = !vld5_reg || out_rdy;
    assign in_rdy = en5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld5_reg <= 1'b0;
        else if (en5)
            vld5_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            red_reg   <= scale(r_sel, common_anode);
            green_reg <= scale(g_sel, common_anode);
            blue_reg  <= scale(b_sel, common_anode);
        end
    end

    assign out_vld    = vld5_reg;
    assign red_duty   = red_reg;
    assign green_duty = green_reg;
    assign blue_duty  = blue_reg;

endmodule

// File: rtl/hsvled_checker.sv
// ----------------------------------------------------------------------------
// hsvled_checker
// Port-level checks on flow and latency of the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
module hsvled_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [hsvled_pkg::OUT_W-1:0] red_duty,
    input logic [hsvled_pkg::OUT_W-1:0] green_duty,
    input logic [hsvled_pkg::OUT_W-1:0] blue_duty
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // and keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(red_duty) && $stable(green_duty) && $stable(blue_duty))
        else $error("stalled result changed");

    // a sink that is ready frees every stage
    a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output ready");

    // a request reaches the output while the sink stays ready behind it
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
            ##1 out_ready |=> out_valid)
        else $error("request not delivered after five cycles");

endmodule

bind hsv_to_rgb_led_drive_unit hsvled_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (hsv_chan.valid),
    .in_ready   (hsv_chan.ready),
    .out_valid  (rgb_chan.valid),
    .out_ready  (rgb_chan.ready),
    .red_duty   (rgb_chan.red_duty),
    .green_duty (rgb_chan.green_duty),
    .blue_duty  (rgb_chan.blue_duty)
);

// File: sim/hsv_to_rgb_led_drive_unit_tb.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_drive_unit_tb
// Drives HSV requests into the duty pipeline under random backpressure and
// idle gaps, predicts each RGB duty triple in fixed point and checks results
// in order. The common-anode register is switched between phases.
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_drive_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsvled_pkg::*;

    localparam int        FRAC        = 16;
    localparam int        DUTY_MAX    = 255;
    localparam int        HUE_SECTORS = 6;
    localparam bit [63:0] UNIT        = 64'd1 << FRAC;
    localparam int        HOLD_CYCLES = 300;

    typedef struct packed {
        logic [IN_W-1:0] hue;
        logic [IN_W-1:0] sat;
        logic [IN_W-1:0] val;
    } hsv_req_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } duty_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    hsvled_in_if  hsv_chan ();
    hsvled_out_if rgb_chan ();

    hsv_to_rgb_led_drive_unit #(
        .FRAC_BITS (FRAC),
        .OUT_MAX   (DUTY_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_chan  (hsv_chan),
        .rgb_chan  (rgb_chan),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    hsv_req_t hsv_pending_q[$];
    duty_t    duty_expect_q[$];
    hsv_req_t next_req;
    duty_t    got_duty;
    duty_t    want_duty;
    bit       anode_shadow;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       phase_no;
    int       n_taken;
    int       hold_mark;
    int       hold_left;
    bit       hold_done;
    int       fail_cnt;

    // ------------------------------------------------------------------
    // Fixed-point color prediction
    // ------------------------------------------------------------------
    function automatic bit [63:0] unit_magnitude(logic [IN_W-1:0] raw);
        bit [63:0] mag;
        mag = raw[IN_W-1] ? ((64'd1 << IN_W) - {40'd0, raw}) : {40'd0, raw};
        // above 1.0 keeps only the fraction; exactly 1.0 survives
        if (mag > UNIT)
            mag = mag & (UNIT - 1);
        return mag;
    endfunction

    function automatic logic [OUT_W-1:0] scale_duty(bit [63:0] c, bit anode);
        bit [63:0] d;
        d = (c * DUTY_MAX + (UNIT >> 1)) >> FRAC;
        if (d > DUTY_MAX)
            d = DUTY_MAX;
        if (anode)
            d = DUTY_MAX - d;
        return d[OUT_W-1:0];
    endfunction

    function automatic duty_t hsv_to_duty(hsv_req_t req, bit anode);
        bit [63:0] h, s, v, h6, f, fs, p, q, t, r, g, b;
        sector_t   sec;
        duty_t     res;
        h  = unit_magnitude(req.hue);
        s  = unit_magnitude(req.sat);
        v  = unit_magnitude(req.val);
        h6 = h * HUE_SECTORS;
        sec = h6[FRAC+2:FRAC];
        f  = h6 & (UNIT - 1);
        if (sec == SEC_WRAP)
            sec = SEC_R_Y;
        fs = (f * s) >> FRAC;
        p  = (v * (UNIT - s)) >> FRAC;
        q  = (v * (UNIT - fs)) >> FRAC;
        t  = (v * (UNIT - s + fs)) >> FRAC;
        case (sec)
            SEC_R_Y: begin r = v; g = t; b = p; end
            SEC_Y_G: begin r = q; g = v; b = p; end
            SEC_G_C: begin r = p; g = v; b = t; end
            SEC_C_B: begin r = p; g = q; b = v; end
            SEC_B_M: begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
        endcase
        res.red   = scale_duty(r, anode);
        res.green = scale_duty(g, anode);
        res.blue  = scale_duty(b, anode);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hsv_chan.valid  <= 1'b0;
            hsv_chan.hue_in <= '0;
            hsv_chan.sat_in <= '0;
            hsv_chan.val_in <= '0;
        end
        else
        begin
            if (hsv_chan.valid && hsv_chan.ready)
            begin
                duty_expect_q.push_back(hsv_to_duty({hsv_chan.hue_in, hsv_chan.sat_in,
                                                     hsv_chan.val_in}, anode_shadow));
                n_taken <= n_taken + 1;
            end
            if (!hsv_chan.valid || hsv_chan.ready)
            begin
                if (hsv_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = hsv_pending_q.pop_front();
                    hsv_chan.valid  <= 1'b1;
                    hsv_chan.hue_in <= next_req.hue;
                    hsv_chan.sat_in <= next_req.sat;
                    hsv_chan.val_in <= next_req.val;
                end
                else
                begin
                    hsv_chan.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: ready pattern with one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rgb_chan.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rgb_chan.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && phase_no == 2 && n_taken >= hold_mark)
        begin
            rgb_chan.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            rgb_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(string name, logic [OUT_W-1:0] exp_v, logic [OUT_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rgb_chan.valid && rgb_chan.ready)
        begin
            got_duty = {rgb_chan.red_duty, rgb_chan.green_duty, rgb_chan.blue_duty};
            if (duty_expect_q.size() == 0)
            begin
                $error("duty result with no request outstanding: %0d %0d %0d",
                       got_duty.red, got_duty.green, got_duty.blue);
                fail_cnt++;
            end
            else
            begin
                want_duty = duty_expect_q.pop_front();
                check_field("red_duty", want_duty.red, got_duty.red);
                check_field("green_duty", want_duty.green, got_duty.green);
                check_field("blue_duty", want_duty.blue, got_duty.blue);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [IN_W-1:0] pick_field();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return IN_W'($urandom_range(65536));
        else if (sel < 60)
            return IN_W'(-$urandom_range(65536));
        else if (sel < 85)
            return IN_W'($urandom());
        case ($urandom_range(7))
            0: return '0;
            1: return IN_W'(UNIT);
            2: return IN_W'(-UNIT);
            3: return {1'b0, {(IN_W-1){1'b1}}};
            4: return {1'b1, {(IN_W-1){1'b0}}};
            5: return IN_W'(UNIT - 1);
            6: return IN_W'(UNIT + 1);
            // near a sector boundary
            default: return IN_W'(10922 + $urandom_range(2) + 10923 * $urandom_range(5));
        endcase
    endfunction

    task automatic queue_hsv(int h, int s, int v);
        hsv_pending_q.push_back({IN_W'(h), IN_W'(s), IN_W'(v)});
    endtask

    task automatic queue_random(int count);
        repeat (count)
            hsv_pending_q.push_back({pick_field(), pick_field(), pick_field()});
    endtask

    // all requests taken and every result back; sampled away from the edge
    task automatic wait_drained();
        @(negedge clk);
        while (hsv_pending_q.size() != 0 || hsv_chan.valid || duty_expect_q.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_anode(bit value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        anode_shadow = value;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        hsv_chan.valid  = 1'b0;
        hsv_chan.hue_in = '0;
        hsv_chan.sat_in = '0;
        hsv_chan.val_in = '0;
        rgb_chan.ready  = 1'b0;
        anode_shadow    = 1'b0;
        send_idle_pct   = 36;
        recv_idle_pct   = 79;
        phase_no        = 0;
        n_taken         = 0;
        hold_mark       = 0;
        hold_left       = 0;
        hold_done       = 1'b0;
        fail_cnt        = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_anode(1'b0);

        // directed: extremes, every sector, wrap and most negative inputs
        queue_hsv(0, 0, 0);
        queue_hsv(65536, 65536, 65536);
        queue_hsv(-8388608, -8388608, -8388608);
        queue_hsv(8388607, 8388607, 8388607);
        queue_hsv(-1, -1, -1);
        queue_hsv(65535, 65535, 65535);
        queue_hsv(65537, 65537, 65537);
        queue_hsv(5461, 65536, 65536);
        queue_hsv(16384, 65536, 65536);
        queue_hsv(27307, 65536, 65536);
        queue_hsv(38229, 65536, 65536);
        queue_hsv(49152, 65536, 65536);
        queue_hsv(60075, 65536, 65536);
        queue_hsv(10923, 32768, 65536);
        queue_hsv(21845, 65536, 32768);
        queue_hsv(-16384, -32768, -65536);
        queue_hsv(40000, 0, 65536);
        queue_hsv(54613, 49152, 128);
        queue_hsv(32768, 1, 65535);
        queue_hsv(8388607, 0, 65536);
        wait_drained();

        write_anode(1'b1);
        queue_hsv(0, 0, 0);
        queue_hsv(65536, 65536, 65536);
        queue_hsv(-8388608, 65536, 65536);
        queue_random(580);
        wait_drained();

        phase_no      = 1;
        send_idle_pct = 79;
        recv_idle_pct = 36;
        write_anode(1'b0);
        queue_random(600);
        wait_drained();

        // no idling; the result side stalls long enough to back up the pipe
        phase_no      = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_mark     = n_taken + 40;
        write_anode(1'b1);
        queue_random(700);
        wait_drained();

        if (fail_cnt == 0 && duty_expect_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
